[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds in a cycle, consequent holds in the same cycle
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent holds in a cycle, consequent holds in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[design/hotl_pkg.sv]
`default_nettype none

package hotl_pkg;

  // scan phase codes
  localparam logic [3:0] PH_START      = 4'd0;
  localparam logic [3:0] PH_LT         = 4'd1;
  localparam logic [3:0] PH_BANG       = 4'd2;
  localparam logic [3:0] PH_BANG_DASH  = 4'd3;
  localparam logic [3:0] PH_COMMENT    = 4'd4;
  localparam logic [3:0] PH_DECL       = 4'd5;
  localparam logic [3:0] PH_PI         = 4'd6;
  localparam logic [3:0] PH_NAME       = 4'd7;
  localparam logic [3:0] PH_GAP        = 4'd8;
  localparam logic [3:0] PH_SLASH      = 4'd9;
  localparam logic [3:0] PH_ATTR       = 4'd10;
  localparam logic [3:0] PH_AFTER_ATTR = 4'd11;
  localparam logic [3:0] PH_VAL_START  = 4'd12;
  localparam logic [3:0] PH_QUOTED     = 4'd13;
  localparam logic [3:0] PH_UNQUOTED   = 4'd14;
  localparam logic [3:0] PH_DONE       = 4'd15;

  // match kinds
  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_TAG     = 3'd1;
  localparam logic [2:0] KIND_COMMENT = 3'd2;
  localparam logic [2:0] KIND_DECL    = 3'd3;
  localparam logic [2:0] KIND_PI      = 3'd4;

  localparam logic [2:0] SEEN_MAX = 3'd7;

  // characters
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;

  typedef struct packed {
    logic       hit;
    logic [2:0] kind;
  } verdict_t;

  function automatic logic is_ws(input logic [7:0] c);
    return c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
  endfunction

  function automatic logic name_first(input logic [7:0] c);
    return (c == CH_UNDER) || (c == CH_COLON) || (c inside {[8'h41:8'h5A]})
        || (c inside {[8'h61:8'h7A]});
  endfunction

  function automatic logic name_rest(input logic [7:0] c);
    return name_first(c) || (c == CH_DASH) || (c == CH_DOT) || (c inside {[8'h30:8'h39]});
  endfunction

endpackage

`default_nettype wire

[design/html_open_tag_line_recognizer.sv]
// a line's verdict appears on the output in the cycle after its last byte is accepted
// throughput: one byte per cycle; a byte stalls only while a finished verdict is not taken
// the per-byte scan state machine and the single output register set this timing
// reset (asynchronous, active low) returns the scanner to the start of a line
// and empties the output register
`default_nettype none

module html_open_tag_line_recognizer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] line_byte_i,
  input  wire logic       end_of_line_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            is_open_tag_o,
  output logic [2:0]      match_kind_o
);
  import hotl_pkg::*;

  logic     accept;
  logic     space;
  logic     verdict_valid;
  verdict_t verdict;

  assign in_ready_o = space;
  assign accept     = in_valid_i && space;

  hotl_scanner u_scanner (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .line_byte_i     (line_byte_i),
    .end_of_line_i   (end_of_line_i),
    .verdict_o       (verdict),
    .verdict_valid_o (verdict_valid)
  );

  hotl_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (verdict_valid),
    .verdict_i     (verdict),
    .space_o       (space),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .is_open_tag_o (is_open_tag_o),
    .match_kind_o  (match_kind_o)
  );

endmodule

`default_nettype wire

[design/hotl_scanner.sv]
`default_nettype none

module hotl_scanner (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [7:0]        line_byte_i,
  input  wire logic              end_of_line_i,
  output hotl_pkg::verdict_t     verdict_o,
  output logic                   verdict_valid_o
);
  import hotl_pkg::*;

  `include "assert_macros.svh"

  logic [3:0]  phase_q, phase_d;
  logic [2:0]  seen_q, seen_d;
  logic [15:0] recent_q;
  logic [23:0] recent_d;
  logic        quote_single_q, quote_single_d;
  logic [2:0]  decided_q, decided_d;

  logic [7:0]  c;
  logic [3:0]  gap_phase;
  logic [2:0]  gap_kind;
  logic [2:0]  kind;

  assign c = line_byte_i;

  // byte where whitespace, attribute name, '>' or '/>' may follow
  always_comb begin
    gap_kind = KIND_NONE;
    if (is_ws(c)) begin
      gap_phase = PH_GAP;
    end else if (c == CH_GT) begin
      gap_phase = PH_DONE;
      gap_kind  = KIND_TAG;
    end else if (c == CH_SLASH) begin
      gap_phase = PH_SLASH;
    end else if (name_first(c)) begin
      gap_phase = PH_ATTR;
    end else begin
      gap_phase = PH_DONE;
    end
  end

  always_comb begin
    phase_d        = phase_q;
    decided_d      = decided_q;
    quote_single_d = quote_single_q;
    case (phase_q)
      PH_START: begin
        if (c == CH_LT) phase_d = PH_LT;
        else phase_d = PH_DONE;
      end
      PH_LT: begin
        if (c == CH_BANG) phase_d = PH_BANG;
        else if (c == CH_QMARK) phase_d = PH_PI;
        else if (name_first(c)) phase_d = PH_NAME;
        else phase_d = PH_DONE;
      end
      PH_BANG:      phase_d = (c == CH_DASH) ? PH_BANG_DASH : PH_DECL;
      PH_BANG_DASH: phase_d = (c == CH_DASH) ? PH_COMMENT : PH_DECL;
      PH_NAME: begin
        if (!name_rest(c)) begin
          phase_d = gap_phase;
          if (gap_phase == PH_DONE) decided_d = gap_kind;
        end
      end
      PH_GAP: begin
        phase_d = gap_phase;
        if (gap_phase == PH_DONE) decided_d = gap_kind;
      end
      PH_SLASH: begin
        phase_d   = PH_DONE;
        decided_d = (c == CH_GT) ? KIND_TAG : KIND_NONE;
      end
      PH_ATTR: begin
        if (name_rest(c)) begin
          phase_d = PH_ATTR;
        end else if (is_ws(c)) begin
          phase_d = PH_AFTER_ATTR;
        end else if (c == CH_EQ) begin
          phase_d = PH_VAL_START;
        end else begin
          phase_d = gap_phase;
          if (gap_phase == PH_DONE) decided_d = gap_kind;
        end
      end
      PH_AFTER_ATTR: begin
        if (is_ws(c)) begin
          phase_d = PH_AFTER_ATTR;
        end else if (c == CH_EQ) begin
          phase_d = PH_VAL_START;
        end else begin
          phase_d = gap_phase;
          if (gap_phase == PH_DONE) decided_d = gap_kind;
        end
      end
      PH_VAL_START: begin
        if (is_ws(c)) begin
          phase_d = PH_VAL_START;
        end else if (c == CH_DQUOTE) begin
          quote_single_d = 1'b0;
          phase_d        = PH_QUOTED;
        end else if (c == CH_SQUOTE) begin
          quote_single_d = 1'b1;
          phase_d        = PH_QUOTED;
        end else if (c inside {CH_EQ, CH_LT, CH_GT, CH_BTICK}) begin
          phase_d   = PH_DONE;
          decided_d = KIND_NONE;
        end else begin
          phase_d = PH_UNQUOTED;
        end
      end
      PH_QUOTED: begin
        if (c == (quote_single_q ? CH_SQUOTE : CH_DQUOTE)) phase_d = PH_GAP;
      end
      PH_UNQUOTED: begin
        if (is_ws(c) || (c inside {CH_DQUOTE, CH_SQUOTE, CH_EQ, CH_LT, CH_GT, CH_BTICK}))
        begin
          phase_d = gap_phase;
          if (gap_phase == PH_DONE) decided_d = gap_kind;
        end
      end
      default: ;
    endcase
  end

  assign seen_d   = (seen_q == SEEN_MAX) ? seen_q : seen_q + 3'd1;
  // only the two older bytes are kept, the newest is the current byte
  assign recent_d = {recent_q, c};

  // line verdict from the state after this byte
  always_comb begin
    kind = KIND_NONE;
    if (seen_d >= 3'd3) begin
      case (phase_d)
        PH_DONE: kind = decided_d;
        PH_COMMENT: begin
          if (seen_d == SEEN_MAX && recent_d == {CH_DASH, CH_DASH, CH_GT}) kind = KIND_COMMENT;
        end
        PH_DECL: begin
          if (recent_d[7:0] == CH_GT) kind = KIND_DECL;
        end
        PH_PI: begin
          if (seen_d >= 3'd4 && recent_d[15:0] == {CH_QMARK, CH_GT}) kind = KIND_PI;
        end
        default: kind = KIND_NONE;
      endcase
    end
  end

  assign verdict_o       = {(kind != KIND_NONE), kind};
  assign verdict_valid_o = accept_i && end_of_line_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_START;
      seen_q         <= 3'd0;
      recent_q       <= 16'd0;
      quote_single_q <= 1'b0;
      decided_q      <= KIND_NONE;
    end else if (accept_i) begin
      if (end_of_line_i) begin
        phase_q        <= PH_START;
        seen_q         <= 3'd0;
        recent_q       <= 16'd0;
        quote_single_q <= 1'b0;
        decided_q      <= KIND_NONE;
      end else begin
        phase_q        <= phase_d;
        seen_q         <= seen_d;
        recent_q       <= recent_d[15:0];
        quote_single_q <= quote_single_d;
        decided_q      <= decided_d;
      end
    end
  end

  `ASSERT_NEXT(a_line_end_clears, clk_i, rst_ni, accept_i && end_of_line_i,
               phase_q == PH_START && seen_q == 3'd0 && decided_q == KIND_NONE)
  `ASSERT_SAME(a_decided_only_done, clk_i, rst_ni, decided_q != KIND_NONE,
               phase_q == PH_DONE)
  `ASSERT_SAME(a_comment_needs_seven, clk_i, rst_ni,
               verdict_valid_o && kind == KIND_COMMENT, seen_d == SEEN_MAX)

endmodule

`default_nettype wire

[design/hotl_out_reg.sv]
`default_nettype none

module hotl_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire hotl_pkg::verdict_t verdict_i,
  output logic                   space_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   is_open_tag_o,
  output logic [2:0]             match_kind_o
);
  import hotl_pkg::*;

  `include "assert_macros.svh"

  logic     valid_q;
  verdict_t data_q;

  // a waiting result blocks only when it is not being taken this cycle
  assign space_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= verdict_i;
    end
  end

  assign out_valid_o   = valid_q;
  assign is_open_tag_o = data_q.hit;
  assign match_kind_o  = data_q.kind;

  `ASSERT_SAME(a_hit_matches_kind, clk_i, rst_ni, valid_q,
               is_open_tag_o == (match_kind_o != KIND_NONE))
  `ASSERT_SAME(a_kind_in_range, clk_i, rst_ni, valid_q,
               match_kind_o == KIND_NONE || match_kind_o == KIND_TAG ||
               match_kind_o == KIND_COMMENT || match_kind_o == KIND_DECL ||
               match_kind_o == KIND_PI)
  `ASSERT_SAME(a_no_overwrite, clk_i, rst_ni, load_i, space_o)

endmodule

`default_nettype wire
